/* rtl/core/r12bu_pkg.sv */
package r12bu_pkg;

	// Frame geometry limits
	localparam int MaxWidth     = 8192;
	localparam int MaxHeight    = 8192;
	localparam int MaxWidthEven = ((MaxWidth & ~1) < 2) ? 2 : (MaxWidth & ~1);
	localparam int MaxHeightLim = (MaxHeight < 1) ? 1 : MaxHeight;

	// Field and register widths
	localparam int CfgW   = 14;
	localparam int ColW   = $clog2(MaxWidthEven);
	localparam int RowW   = (MaxHeightLim > 1) ? $clog2(MaxHeightLim) : 1;
	localparam int IdxW   = 24;
	localparam int RawW   = 12;
	localparam int ByteW  = 8;
	localparam int AddrW  = 3;
	localparam int DataW  = 32;

	localparam logic [3:0] LowNibble = 4'hF;

	// Register map, decoded on address bit two
	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	// Bayer channel codes
	localparam logic [1:0] ChRed    = 2'd0;
	localparam logic [1:0] ChGreen1 = 2'd1;
	localparam logic [1:0] ChGreen2 = 2'd2;
	localparam logic [1:0] ChBlue   = 2'd3;

	// Byte position within a packed triple
	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_MID   = 2'd1,
		PH_LAST  = 2'd2
	} phase_t;

	// Unpacked pixel handed from the unpack stage to the tag stage
	typedef struct packed {
		logic            vld;
		logic [RawW-1:0] raw;
	} pix_t;

	// Last column and last row positions of the current frame
	typedef struct packed {
		logic [ColW-1:0] last_col;
		logic [RowW-1:0] last_row;
	} geom_t;

endpackage

/* rtl/core/r12bu_regs.sv */
module r12bu_regs
	import r12bu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output geom_t            geom
);

	logic [CfgW-1:0] width_q;
	logic [CfgW-1:0] height_q;
	logic            wr_en;
	logic [CfgW-1:0] width_even;
	int              w_eff;
	int              h_eff;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Write frame size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CfgW'(1920);
			height_q <= CfgW'(1080);
		end else if (wr_en) begin
			unique case (paddr[2])
				RegWidth:  width_q  <= pwdata[CfgW-1:0];
				RegHeight: height_q <= pwdata[CfgW-1:0];
				default:   ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			RegWidth:  prdata = DataW'(width_q);
			RegHeight: prdata = DataW'(height_q);
			default:   prdata = '0;
		endcase
	end

	// Clamp width to an even value in range, height to at least one row and at most MaxHeight rows
	assign width_even = {width_q[CfgW-1:1], 1'b0};

	always_comb begin
		w_eff = int'(width_even);
		if (w_eff > MaxWidthEven) w_eff = MaxWidthEven;
		if (w_eff < 2) w_eff = 2;
		h_eff = int'(height_q);
		if (h_eff > MaxHeightLim) h_eff = MaxHeightLim;
		if (h_eff < 1) h_eff = 1;
	end

	assign geom.last_col = ColW'(w_eff - 1);
	assign geom.last_row = RowW'(h_eff - 1);

endmodule

/* rtl/core/r12bu_unpack.sv */
module r12bu_unpack
	import r12bu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             take,
	input  logic [ByteW-1:0] data_byte,
	output pix_t             pix_s1
);

	phase_t           phase_q;
	phase_t           phase_d;
	logic [ByteW-1:0] held_q;
	pix_t             pix_d;

	// Next byte position
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (phase_q)
				PH_MID:  phase_d = PH_LAST;
				PH_LAST: phase_d = PH_FIRST;
				default: phase_d = PH_MID;
			endcase
		end
	end

	// Assemble a pixel on the second and third byte of a triple
	always_comb begin
		pix_d.vld = 1'b0;
		pix_d.raw = '0;
		if (take) begin
			unique case (phase_q)
				PH_MID: begin
					pix_d.vld = 1'b1;
					pix_d.raw = {held_q, data_byte[7:4] & LowNibble};
				end
				PH_LAST: begin
					pix_d.vld = 1'b1;
					pix_d.raw = {held_q[3:0] & LowNibble, data_byte};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			held_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			if (phase_q != PH_LAST) held_q <= data_byte;
		end
	end

	// Stage register, holds while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else if (adv) begin
			pix_s1.vld <= pix_d.vld;
			if (pix_d.vld) pix_s1.raw <= pix_d.raw;
		end
	end

endmodule

/* rtl/core/r12bu_tag.sv */
module r12bu_tag
	import r12bu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  pix_t            pix_s1,
	input  geom_t           geom,
	output logic            vld_s2,
	output logic [RawW-1:0] raw_s2,
	output logic [7:0]      p8_s2,
	output logic [1:0]      chan_s2,
	output logic [IdxW-1:0] idx_s2,
	output logic            eof_s2
);

	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [IdxW-1:0] rg_idx_q;
	logic [IdxW-1:0] gb_idx_q;
	logic            odd_col;
	logic            odd_row;
	logic            last_col;
	logic            last_row;
	logic            eof;
	logic            step;

	assign step     = adv && pix_s1.vld;
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];
	assign last_col = col_q >= geom.last_col;
	assign last_row = row_q >= geom.last_row;
	assign eof      = last_col && last_row;

	// Advance raster position and plane indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			rg_idx_q <= '0;
			gb_idx_q <= '0;
		end else if (step) begin
			if (eof) begin
				col_q    <= '0;
				row_q    <= '0;
				rg_idx_q <= '0;
				gb_idx_q <= '0;
			end else begin
				if (odd_col && odd_row) gb_idx_q <= gb_idx_q + IdxW'(1);
				if (odd_col && !odd_row) rg_idx_q <= rg_idx_q + IdxW'(1);
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + RowW'(1);
				end else begin
					col_q <= col_q + ColW'(1);
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= pix_s1.vld;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			raw_s2  <= pix_s1.raw;
			p8_s2   <= pix_s1.raw[RawW-1:4];
			chan_s2 <= {odd_row, odd_col};
			idx_s2  <= odd_row ? gb_idx_q : rg_idx_q;
			eof_s2  <= eof;
		end
	end

endmodule

/* rtl/core/raw12_bayer_unpacker.sv */
// Packed RAW12 unpacker with Bayer RGGB tagging. Takes one byte of the packed
// stream per clock while in_stall is low; every three bytes yield two pixels,
// on the second and third byte. A completed pixel passes through the unpack
// register stage, then the tag and output register stage, both held as a unit
// while a finished pixel waits at the output with out_stall high. Each pixel
// carries its 12-bit and 8-bit value, its channel (0 red, 1 green1, 2 green2,
// 3 blue) and its index in that plane; end_of_frame marks the last pixel of
// the frame and restarts the counters. Frame width (even, 2..8192) and height
// (1..8192) sit at APB addresses 0 and 4; write them only while no pixel is in
// flight.
module raw12_bayer_unpacker
	import r12bu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ByteW-1:0] data_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RawW-1:0]  pixel_raw,
	output logic [7:0]       pixel_8bit,
	output logic [1:0]       bayer_channel,
	output logic [IdxW-1:0]  channel_index,
	output logic             end_of_frame
);

	geom_t geom;
	pix_t  pix_s1;
	logic  adv;
	logic  take;

	// Whole pipe advances unless a finished pixel is stalled
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign take     = in_valid && adv;

	r12bu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	r12bu_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.take      (take),
		.data_byte (data_byte),
		.pix_s1    (pix_s1)
	);

	r12bu_tag u_tag (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.pix_s1  (pix_s1),
		.geom    (geom),
		.vld_s2  (out_valid),
		.raw_s2  (pixel_raw),
		.p8_s2   (pixel_8bit),
		.chan_s2 (bayer_channel),
		.idx_s2  (channel_index),
		.eof_s2  (end_of_frame)
	);

endmodule

/* rtl/core/r12bu_checker.sv */
module r12bu_checker
	import r12bu_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [RawW-1:0] pixel_raw,
	input logic [7:0]      pixel_8bit
);

	// Stalled pixel stays offered and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_raw))
		else $error("stalled pixel dropped or changed");

	// Byte input backs up whenever a pixel is stalled
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("byte taken while pixel stalled");

	// 8-bit value is the top of the 12-bit value
	a_pix8: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_8bit == pixel_raw[RawW-1:4])
		else $error("8-bit pixel mismatch");

endmodule

bind raw12_bayer_unpacker r12bu_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_raw  (pixel_raw),
	.pixel_8bit (pixel_8bit)
);
